### rtl/chlp_pkg.sv
// Package for the chunk header line parser.
// Holds character codes, result kind codes, the queue bundle type and default sizes.
// Used by every module of the block; depends on nothing.
package chlp_pkg;

  // Default sizes
  localparam int MAX_EXT_DFLT     = 8;
  localparam int TOKEN_SIZE_DFLT  = 32;
  localparam int QUEUE_DEPTH_DFLT = 4;

  // Character codes
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF_A = 8'h66;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_EQ   = 8'h3d;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_LINE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  // One result slot, fields already cut to port width
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  nb;
    logic [2:0]  idx;
    logic [4:0]  len;
  } slot_t;

  // All results caused by one input byte (one to three)
  typedef struct packed {
    logic [1:0]      n_res;
    slot_t [2:0]     slots;
    logic [31:0]     size;
    logic [3:0]      cnt;
    logic            ovf;
  } bundle_t;

endpackage

### rtl/chunk_header_line_parser.sv
// Top level of the chunk header line parser: front end, bundle queue, result stage.
// Depends on chlp_pkg, chlp_front, chlp_queue and chlp_back.
//
// Parses one chunk header line per buffer, one byte per transfer: the hex chunk size,
// then the names of up to MAX_EXT extensions, and reports each name byte up to
// TOKEN_SIZE - 1 per name, each name end, a line done result after the first CR LF,
// and an error if the buffer ends without one. A byte is taken in the cycle it is
// offered unless full is high, and all of its results (up to three) are worked out in
// that cycle and stored as one entry in a queue of QUEUE_DEPTH entries; full rises
// only when that queue is full. Results leave one per pop, so input runs at one byte
// per cycle as long as results are popped each cycle and bytes average at most one
// result each; bytes with two or three results take more pops, absorbed by the queue.
module chunk_header_line_parser import chlp_pkg::*; #(
  parameter int MAX_EXT     = MAX_EXT_DFLT,     // 1 to 8
  parameter int TOKEN_SIZE  = TOKEN_SIZE_DFLT,  // 2 to 32
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DFLT  // 2 or more
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [7:0]  name_byte,
  output logic [2:0]  ext_index,
  output logic [4:0]  name_length,
  output logic [31:0] chunk_size,
  output logic [3:0]  ext_count,
  output logic        size_overflow,
  output logic        last_result
);

  logic                             take;
  logic                             b_vld;
  bundle_t                          b_data;
  bundle_t                          q_head;
  logic                             q_vld;
  logic                             q_pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  assign take = push && !full;

  chlp_front #(
    .MAX_EXT    (MAX_EXT),
    .TOKEN_SIZE (TOKEN_SIZE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .bundle_vld (b_vld),
    .bundle     (b_data)
  );

  chlp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (b_vld),
    .wr_data (b_data),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .vld     (q_vld),
    .full    (full),
    .count   (q_count)
  );

  chlp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_vld         (q_vld),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .result_kind   (result_kind),
    .name_byte     (name_byte),
    .ext_index     (ext_index),
    .name_length   (name_length),
    .chunk_size    (chunk_size),
    .ext_count     (ext_count),
    .size_overflow (size_overflow),
    .last_result   (last_result)
  );

`ifndef SYNTHESIS
  // Queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QUEUE_DEPTH)
    else $error("bundle queue over its depth");

  // A missing CR LF error always closes the results of its byte
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == KIND_ERR) |-> last_result)
    else $error("error result not marked last");

  // A bundle leaves the queue exactly when its last result is transferred
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && last_result && !b_vld) |=> (q_count == $past(q_count) - 1'b1))
    else $error("queue did not drop a finished bundle");

  // A stored name length stays below the token size
  a_name_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == KIND_END) |-> (name_length <= TOKEN_SIZE - 1))
    else $error("name length beyond token size");
`endif

endmodule

### rtl/chlp_front.sv
// Front end of the chunk header line parser: takes bytes, runs the line parser
// state and packs the results of each byte into one bundle for the queue.
// Depends on chlp_pkg.
module chlp_front import chlp_pkg::*; #(
  parameter int MAX_EXT    = MAX_EXT_DFLT,
  parameter int TOKEN_SIZE = TOKEN_SIZE_DFLT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       bundle_vld,
  output bundle_t    bundle
);

  localparam int CW = $clog2(MAX_EXT + 1);
  localparam int LW = $clog2(TOKEN_SIZE);

  typedef enum logic [5:0] {
    PH_HEAD  = 6'b000001,
    PH_SKIP  = 6'b000010,
    PH_NAME  = 6'b000100,
    PH_VALUE = 6'b001000,
    PH_FULL  = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t          phase;
    logic [31:0]     acc;
    logic            hex_open;
    logic            ovf;
    logic [CW-1:0]   cnt;
    logic [LW-1:0]   len;
  } pst_t;

  typedef struct packed {
    pst_t  st;
    logic  vld;
    slot_t slot;
  } step_t;

  // Parse one byte against the state; at most one result comes out
  function automatic step_t proc(pst_t st, logic [7:0] b);
    step_t      r;
    logic [3:0] dig;
    logic       is_dig;
    logic       end_nm;
    logic       open_nx;
    r       = '{st: st, vld: 1'b0, slot: '0};
    dig     = '0;
    is_dig  = 1'b0;
    end_nm  = 1'b0;
    open_nx = 1'b0;
    unique case (st.phase) inside
      PH_HEAD: begin
        if (st.hex_open) begin
          if (b >= CH_0 && b <= CH_9) begin
            is_dig = 1'b1;
            dig    = b[3:0];
          end else if ((b >= CH_LA && b <= CH_LF_A) || (b >= CH_UA && b <= CH_UF)) begin
            is_dig = 1'b1;
            dig    = b[3:0] + 4'd9;
          end
          if (is_dig) begin
            r.st.ovf = st.ovf | (|st.acc[31:28]);
            r.st.acc = {st.acc[27:0], dig};
          end else begin
            r.st.hex_open = 1'b0;
          end
        end
        open_nx = (b == CH_SEMI);
      end
      PH_SKIP, PH_NAME: begin
        if (b == CH_SEMI) begin
          end_nm  = 1'b1;
          open_nx = 1'b1;
        end else if (b == CH_EQ) begin
          end_nm      = 1'b1;
          r.st.phase  = PH_VALUE;
        end else if (st.phase == PH_NAME || (b != CH_SP && b != CH_TAB)) begin
          r.st.phase = PH_NAME;
          if (st.len < LW'(TOKEN_SIZE - 1)) begin
            r.vld    = 1'b1;
            r.slot   = '{kind: KIND_BYTE, nb: b, idx: 3'(st.cnt), len: 5'd0};
            r.st.len = st.len + LW'(1);
          end
        end
      end
      PH_VALUE: open_nx = (b == CH_SEMI);
      default: ;
    endcase
    // Close the current name
    if (end_nm) begin
      r.vld    = 1'b1;
      r.slot   = '{kind: KIND_END, nb: 8'd0, idx: 3'(st.cnt), len: 5'(st.len)};
      r.st.cnt = st.cnt + CW'(1);
    end
    // Open the next extension, or go to the full phase once MAX_EXT are counted
    if (open_nx) begin
      r.st.len   = '0;
      r.st.phase = (r.st.cnt < CW'(MAX_EXT)) ? PH_SKIP : PH_FULL;
    end
    return r;
  endfunction

  pst_t    st, st_next, s1, s2;
  logic    cr_pend, cr_pend_next;
  step_t   p0, p1;
  slot_t   cand [4];
  logic    cand_v [4];
  slot_t   [2:0] slots;
  logic    [1:0] n_res;

  // Work out the next state and the candidate results of this byte
  always_comb begin
    cr_pend_next = cr_pend;
    s1           = st;
    p0           = '{st: st, vld: 1'b0, slot: '0};
    p1           = '{st: st, vld: 1'b0, slot: '0};
    for (int k = 0; k < 4; k++) begin
      cand[k]   = '0;
      cand_v[k] = 1'b0;
    end
    // Resolve a held CR: end of line on LF, else a plain data byte
    if (cr_pend) begin
      cr_pend_next = 1'b0;
      if (data_byte == CH_LF) begin
        if (st.phase == PH_SKIP || st.phase == PH_NAME) begin
          cand_v[0] = 1'b1;
          cand[0]   = '{kind: KIND_END, nb: 8'd0, idx: 3'(st.cnt), len: 5'(st.len)};
          s1.cnt    = st.cnt + CW'(1);
        end
        cand_v[1] = 1'b1;
        cand[1]   = '{kind: KIND_LINE, nb: 8'd0, idx: 3'd0, len: 5'd0};
        s1.phase  = PH_DONE;
      end else begin
        p0        = proc(st, CH_CR);
        s1        = p0.st;
        cand_v[0] = p0.vld;
        cand[0]   = p0.slot;
      end
    end
    // Handle the new byte unless the line is over
    s2 = s1;
    if (s1.phase != PH_DONE) begin
      if (data_byte == CH_CR) begin
        cr_pend_next = 1'b1;
      end else begin
        p1        = proc(s1, data_byte);
        s2        = p1.st;
        cand_v[2] = p1.vld;
        cand[2]   = p1.slot;
      end
    end
    st_next = s2;
    // Close the buffer: flag a missing CR LF, then restart
    if (last_byte) begin
      if (s2.phase != PH_DONE) begin
        cand_v[3] = 1'b1;
        cand[3]   = '{kind: KIND_ERR, nb: 8'd0, idx: 3'd0, len: 5'd0};
      end
      st_next      = '{phase: PH_HEAD, acc: 32'd0, hex_open: 1'b1, ovf: 1'b0,
                       cnt: '0, len: '0};
      cr_pend_next = 1'b0;
    end
  end

  // Pack the valid candidates in order
  always_comb begin
    n_res = 2'd0;
    slots = '0;
    for (int k = 0; k < 4; k++) begin
      if (cand_v[k]) begin
        slots[n_res] = cand[k];
        n_res        = n_res + 2'd1;
      end
    end
  end

  assign bundle_vld = take && (n_res != 2'd0);
  assign bundle     = '{n_res: n_res, slots: slots, size: s1.acc,
                        cnt: 4'(s1.cnt), ovf: s1.ovf};

  // Advance the parser state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= '{phase: PH_HEAD, acc: 32'd0, hex_open: 1'b1, ovf: 1'b0,
                   cnt: '0, len: '0};
      cr_pend <= 1'b0;
    end else if (take) begin
      st      <= st_next;
      cr_pend <= cr_pend_next;
    end
  end

endmodule

### rtl/chlp_queue.sv
// Short bundle queue between the front end and the result stage.
// Holds up to DEPTH bundles, oldest first. Depends on chlp_pkg.
module chlp_queue import chlp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DFLT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  bundle_t                    wr_data,
  input  logic                       rd_en,
  output bundle_t                    rd_data,
  output logic                       vld,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  bundle_t         mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;

  assign vld     = (count != '0);
  assign full    = (count == NW'(DEPTH));
  assign rd_data = mem[rd_ptr];

  // Store incoming bundles
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + NW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

### rtl/chlp_back.sv
// Result stage of the chunk header line parser: steps through the results of
// the bundle at the queue head, one per transfer. Depends on chlp_pkg.
module chlp_back import chlp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_vld,
  input  bundle_t     q_head,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [7:0]  name_byte,
  output logic [2:0]  ext_index,
  output logic [4:0]  name_length,
  output logic [31:0] chunk_size,
  output logic [3:0]  ext_count,
  output logic        size_overflow,
  output logic        last_result
);

  logic [1:0] sel;
  slot_t      cur;
  kind_t      kind;
  logic       take;

  assign cur         = q_head.slots[sel];
  assign kind        = cur.kind;
  assign empty       = !q_vld;
  assign take        = pop && q_vld;
  assign last_result = (sel == q_head.n_res - 2'd1);
  assign q_pop       = take && last_result;

  // Show only the fields that belong to the current kind
  assign result_kind   = kind;
  assign name_byte     = (kind == KIND_BYTE) ? cur.nb : 8'd0;
  assign ext_index     = (kind == KIND_BYTE || kind == KIND_END) ? cur.idx : 3'd0;
  assign name_length   = (kind == KIND_END) ? cur.len : 5'd0;
  assign chunk_size    = (kind == KIND_LINE) ? q_head.size : 32'd0;
  assign ext_count     = (kind == KIND_LINE) ? q_head.cnt : 4'd0;
  assign size_overflow = (kind == KIND_LINE) && q_head.ovf;

  // Advance within the bundle, wrap on its last result
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 2'd0;
    end else if (take) begin
      sel <= last_result ? 2'd0 : sel + 2'd1;
    end
  end

endmodule
